@@ hdl/lzbd_pkg.sv @@
// Shared types, constants and helper functions for the backward LZ bitstream decoder.
`timescale 1ns / 1ps

package lzbd_pkg;

    // History window and per-word emit budget
    localparam int HISTORY_DEPTH     = 16384;
    localparam int HIST_AW           = $clog2(HISTORY_DEPTH);
    localparam int MAX_EMIT_PER_ITEM = 32;
    localparam int BUF_AW            = $clog2(MAX_EMIT_PER_ITEM);
    localparam int COUNT_W           = $clog2(MAX_EMIT_PER_ITEM + 1);

    // Token field widths
    localparam int LIT_BITS   = 8;
    localparam int DIST_BITS  = 13;
    localparam int DIST_BIAS  = 3;
    localparam int LEN_BASE   = 3;
    localparam int LAST_STAGE = 3;

    // Input word kinds carried on tuser
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Position inside the current token
    typedef enum logic [2:0] {
        PH_FLAG,
        PH_LIT,
        PH_DIST,
        PH_LEN,
        PH_COPY
    } phase_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_COPY_WAIT,
        ST_OUT
    } ctl_state_t;

    // One buffered result before its word flags are known
    typedef struct packed {
        logic       bad;
        logic       done;
        logic [7:0] data;
    } res_entry_t;

    // Width of length field for a given stage: 2, 3, 5, then 8
    function automatic logic [3:0] len_width(input logic [1:0] stage);
        logic [3:0] w;
        unique case (stage)
            2'd0:    w = 4'd2;
            2'd1:    w = 4'd3;
            2'd2:    w = 4'd5;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

    // All-ones value of a length field of the given stage
    function automatic logic [7:0] len_mask(input logic [1:0] stage);
        logic [7:0] m;
        unique case (stage)
            2'd0:    m = 8'h03;
            2'd1:    m = 8'h07;
            2'd2:    m = 8'h1F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/lzbd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lzbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/lz_backward_bitstream_decoder.sv @@
// Top level of the backward LZ bitstream decoder: token engine, history and result buffer.
`timescale 1ns / 1ps

// The host feeds compressed bytes from the last toward the first on the s_ side (tuser = 0)
// and drain words (tuser = 1) to collect copy bytes beyond the 32 results one word may give.
// A word is decoded in full into a 32-entry result buffer, then streamed out on the m_ side
// with tlast on its final result; a word that yields nothing gives no result. The token
// engine takes one token bit per step; a copy byte read from history waits in ST_COPY_WAIT
// for the registered read of the history memory, and a copy byte whose source lies before
// the first byte is emitted directly as zero. Buffered results then leave at one per cycle
// as the m_ side takes them, and after the last one the block returns to idle.
// A new word is taken once the previous word's results have all moved to the output register.
// output_size must be written on cfg_we only while the block is idle; the block does not
// enforce this. Decoding stops there.
module lz_backward_bitstream_decoder
    import lzbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,      // output_size
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] compressed_byte
    input  logic        s_tuser,        // [0] kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // [7:0] data_byte
    output logic        m_tlast,        // last_of_run
    output logic [2:0]  m_tuser         // [0] copy_pending, [1] stream_done, [2] bad_distance
);

    // State registers
    ctl_state_t         state_reg,     state_next;
    phase_t             phase_reg,     phase_next;
    logic [31:0]        out_size_reg;
    logic [7:0]         bit_buf_reg,   bit_buf_next;
    logic [3:0]         bits_left_reg, bits_left_next;
    logic [12:0]        acc_reg,       acc_next;
    logic [3:0]         taken_reg,     taken_next;
    logic [1:0]         stage_reg,     stage_next;
    logic [13:0]        dist_reg,      dist_next;
    logic [31:0]        remain_reg,    remain_next;
    logic [31:0]        bp_reg,        bp_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [COUNT_W-1:0] rd_idx_reg,    rd_idx_next;
    logic               pending_reg,   pending_next;
    logic               m_valid_reg,   m_valid_next;
    logic [7:0]         m_data_reg,    m_data_next;
    logic               m_last_reg,    m_last_next;
    logic [2:0]         m_user_reg,    m_user_next;

    // Memory ports
    logic               hist_rd_en;
    logic [HIST_AW-1:0] hist_rd_addr;
    logic [7:0]         hist_q;
    logic               buf_wr_en;
    res_entry_t         buf_wr_data;
    res_entry_t         buf_q;

    // Emit and bit-step helpers
    logic        emit_en;
    logic [7:0]  emit_byte;
    logic        emit_bad;
    logic        copy_step;
    logic        bit_val;
    logic [12:0] acc_shift;
    logic [3:0]  taken_inc;
    logic [32:0] len_sum;
    logic [31:0] bp_inc;
    logic [31:0] src_pos;
    logic        stream_end;
    logic        out_free;

    assign bp_inc     = bp_reg + 32'd1;
    assign src_pos    = bp_reg - 32'(dist_reg);
    assign stream_end = (bp_reg >= out_size_reg);
    assign bit_val    = bit_buf_reg[7];
    assign acc_shift  = {acc_reg[11:0], bit_val};
    assign taken_inc  = taken_reg + 4'd1;
    assign len_sum    = {1'b0, remain_reg} + 33'(acc_shift);
    assign out_free   = !m_valid_reg || m_tready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_size_reg <= '0;
        end else if (cfg_we) begin
            out_size_reg <= cfg_wdata;
        end
    end

    // State register bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_FLAG;
            bit_buf_reg   <= '0;
            bits_left_reg <= '0;
            acc_reg       <= '0;
            taken_reg     <= '0;
            stage_reg     <= '0;
            dist_reg      <= '0;
            remain_reg    <= '0;
            bp_reg        <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pending_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            bit_buf_reg   <= bit_buf_next;
            bits_left_reg <= bits_left_next;
            acc_reg       <= acc_next;
            taken_reg     <= taken_next;
            stage_reg     <= stage_next;
            dist_reg      <= dist_next;
            remain_reg    <= remain_next;
            bp_reg        <= bp_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            pending_reg   <= pending_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    // Sequencer: word intake, token engine, copy reads and result streaming
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        bit_buf_next   = bit_buf_reg;
        bits_left_next = bits_left_reg;
        acc_next       = acc_reg;
        taken_next     = taken_reg;
        stage_next     = stage_reg;
        dist_next      = dist_reg;
        remain_next    = remain_reg;
        bp_next        = bp_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        pending_next   = pending_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        hist_rd_en     = 1'b0;
        hist_rd_addr   = src_pos[HIST_AW-1:0];
        emit_en        = 1'b0;
        emit_byte      = '0;
        emit_bad       = 1'b0;
        copy_step      = 1'b0;
        s_tready       = 1'b0;

        // Drop the output word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && !stream_end) begin
                    // Load a byte only into an empty bit buffer; otherwise treat as drain
                    if (s_tuser == KIND_BYTE && bits_left_reg == 4'd0) begin
                        bit_buf_next   = s_tdata;
                        bits_left_next = 4'd8;
                    end
                    count_next = '0;
                    state_next = ST_RUN;
                end
            end

            ST_RUN: begin
                if (count_reg == COUNT_W'(MAX_EMIT_PER_ITEM) || stream_end ||
                    (phase_reg != PH_COPY && bits_left_reg == 4'd0)) begin
                    // Word finished: latch flags and stream the buffer
                    pending_next = !stream_end &&
                                   (phase_reg == PH_COPY || bits_left_reg != 4'd0);
                    rd_idx_next  = '0;
                    state_next   = (count_reg == '0) ? ST_IDLE : ST_OUT;
                end else if (phase_reg == PH_COPY) begin
                    if (32'(dist_reg) <= bp_reg) begin
                        // Fetch the source byte; distance of at least three keeps
                        // it clear of the entry being written
                        hist_rd_en = 1'b1;
                        state_next = ST_COPY_WAIT;
                    end else begin
                        // Source before the first byte: emit zero, flag it
                        emit_en   = 1'b1;
                        emit_bad  = 1'b1;
                        copy_step = 1'b1;
                    end
                end else begin
                    // Take one bit from the buffer
                    bit_buf_next   = {bit_buf_reg[6:0], 1'b0};
                    bits_left_next = bits_left_reg - 4'd1;
                    acc_next       = acc_shift;
                    taken_next     = taken_inc;
                    unique case (phase_reg)
                        PH_FLAG: begin
                            phase_next = bit_val ? PH_DIST : PH_LIT;
                            acc_next   = '0;
                            taken_next = '0;
                        end
                        PH_LIT: begin
                            if (taken_inc == 4'(LIT_BITS)) begin
                                phase_next = PH_FLAG;
                                emit_en    = 1'b1;
                                emit_byte  = acc_shift[7:0];
                            end
                        end
                        PH_DIST: begin
                            if (taken_inc == 4'(DIST_BITS)) begin
                                dist_next   = {1'b0, acc_shift} + 14'(DIST_BIAS);
                                remain_next = 32'(LEN_BASE);
                                stage_next  = '0;
                                acc_next    = '0;
                                taken_next  = '0;
                                phase_next  = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            if (taken_inc == len_width(stage_reg)) begin
                                remain_next = len_sum[32] ? '1 : len_sum[31:0];
                                if (acc_shift == 13'(len_mask(stage_reg))) begin
                                    if (stage_reg != 2'(LAST_STAGE)) begin
                                        stage_next = stage_reg + 2'd1;
                                    end
                                end else begin
                                    stage_next = '0;
                                    phase_next = PH_COPY;
                                end
                                acc_next   = '0;
                                taken_next = '0;
                            end
                        end
                        default: begin
                            phase_next = PH_FLAG;
                        end
                    endcase
                end
            end

            ST_COPY_WAIT: begin
                // History byte arrives: emit it and go on
                emit_en    = 1'b1;
                emit_byte  = hist_q;
                copy_step  = 1'b1;
                state_next = ST_RUN;
            end

            ST_OUT: begin
                // Move the next buffered result into the output register
                if (rd_idx_reg == count_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = buf_q.data;
                    m_last_next  = (rd_idx_reg == count_reg - COUNT_W'(1));
                    m_user_next  = {buf_q.bad, buf_q.done, pending_reg};
                    rd_idx_next  = rd_idx_reg + COUNT_W'(1);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the copy
        if (copy_step) begin
            remain_next = remain_reg - 32'd1;
            if (remain_reg == 32'd1) begin
                phase_next = PH_FLAG;
            end
        end

        // Count an emitted byte
        if (emit_en) begin
            bp_next    = bp_inc;
            count_next = count_reg + COUNT_W'(1);
        end
    end

    assign buf_wr_en   = emit_en;
    assign buf_wr_data = {emit_bad, (bp_inc >= out_size_reg), emit_byte};

    // History window of produced bytes
    lzbd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (emit_en),
        .wr_addr (bp_reg[HIST_AW-1:0]),
        .wr_data (emit_byte),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_q)
    );

    // Results of the current word; read address follows the next read index
    lzbd_ram #(
        .WIDTH ($bits(res_entry_t)),
        .DEPTH (MAX_EMIT_PER_ITEM)
    ) u_rbuf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (count_reg[BUF_AW-1:0]),
        .wr_data (buf_wr_data),
        .rd_en   (1'b1),
        .rd_addr (rd_idx_next[BUF_AW-1:0]),
        .rd_data (buf_q)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // Never more results than the per-word budget
    a_count_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_EMIT_PER_ITEM))
        else $error("result count beyond budget");

    // A history read is only pending during a copy
    a_copy_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COPY_WAIT |-> phase_reg == PH_COPY)
        else $error("history read outside a copy");

    // History reads only reach already written bytes
    a_hist_src: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_rd_en |-> (32'(dist_reg) <= bp_reg && dist_reg >= 14'(DIST_BIAS)))
        else $error("history read before first byte");

    // The bit buffer never claims more than one byte
    a_bits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= 4'd8)
        else $error("bit count beyond a byte");

    // The output index never passes the buffered count
    a_rd_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> rd_idx_reg <= count_reg)
        else $error("output index beyond buffered results");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the backward LZ bitstream decoder.
`timescale 1ns / 1ps

module tb;
    import lzbd_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_DISTANCE  = (1 << DIST_BITS) - 1 + DIST_BIAS;

    // One decoded byte with its word flags
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pending;
        logic       done;
        logic       bad;
    } out_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    // Decoder shadow state
    logic [31:0] size_limit   = '0;
    logic [7:0]  bit_reg      = '0;
    int          bits_held    = 0;
    phase_t      tok_phase    = PH_FLAG;
    logic [12:0] field_acc    = '0;
    int          field_cnt    = 0;
    int          len_stage    = 0;
    logic [13:0] copy_dist    = '0;
    logic [31:0] copy_left    = '0;
    logic [31:0] produced     = '0;
    logic [7:0]  hist_mem [HISTORY_DEPTH];

    out_byte_t   expected_bytes[$];
    bit          token_bits[$];
    int          gen_count    = 0;
    int          words_sent   = 0;
    int          junk_pct     = 15;
    bit          steady_rate  = 1'b0;
    int          errors       = 0;

    lz_backward_bitstream_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Stall the result side at random unless running at full rate
    always @(posedge aclk) begin
        m_tready <= steady_rate || ($urandom_range(99) >= 34);
    end

    // ---------------------------------------------------------------- prediction

    function automatic int length_field_width(input int stage);
        case (stage)
            0:       return 2;
            1:       return 3;
            2:       return 5;
            default: return 8;
        endcase
    endfunction

    function automatic bit work_left();
        return (produced < size_limit) && (tok_phase == PH_COPY || bits_held != 0);
    endfunction

    // Write one byte to history and count it
    function automatic out_byte_t store_byte(input logic [7:0] value, input logic bad);
        out_byte_t r;
        hist_mem[produced[HIST_AW-1:0]] = value;
        produced = produced + 32'd1;
        r.data    = value;
        r.last    = 1'b0;
        r.pending = 1'b0;
        r.done    = (produced >= size_limit);
        r.bad     = bad;
        return r;
    endfunction

    // Consume one token bit; return 1 when a literal completes
    function automatic bit shift_token_bit(output out_byte_t lit);
        logic        b;
        int          w;
        logic [32:0] sum;
        b = bit_reg[7];
        bit_reg = {bit_reg[6:0], 1'b0};
        bits_held--;
        lit = '0;
        if (tok_phase == PH_FLAG) begin
            tok_phase = b ? PH_DIST : PH_LIT;
            field_acc = '0;
            field_cnt = 0;
            return 1'b0;
        end
        field_acc = {field_acc[11:0], b};
        field_cnt++;
        case (tok_phase)
            PH_LIT: begin
                if (field_cnt >= LIT_BITS) begin
                    tok_phase = PH_FLAG;
                    lit = store_byte(field_acc[7:0], 1'b0);
                    return 1'b1;
                end
            end
            PH_DIST: begin
                if (field_cnt >= DIST_BITS) begin
                    copy_dist = {1'b0, field_acc} + 14'(DIST_BIAS);
                    copy_left = LEN_BASE;
                    len_stage = 0;
                    field_acc = '0;
                    field_cnt = 0;
                    tok_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                w = length_field_width(len_stage);
                if (field_cnt >= w) begin
                    // Saturate the copy length
                    sum = {1'b0, copy_left} + 33'(field_acc);
                    copy_left = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (field_acc == 13'((1 << w) - 1)) begin
                        if (len_stage < LAST_STAGE) len_stage++;
                    end else begin
                        len_stage = 0;
                        tok_phase = PH_COPY;
                    end
                    field_acc = '0;
                    field_cnt = 0;
                end
            end
            default: tok_phase = PH_FLAG;
        endcase
        return 1'b0;
    endfunction

    // Work out the results of one accepted word and queue them
    function automatic void decode_word(input logic kind, input logic [7:0] value);
        out_byte_t   run[$];
        out_byte_t   r;
        logic [31:0] src;
        logic [7:0]  v;
        logic        bad;
        bit          more;
        if (produced >= size_limit) return;
        if (kind == KIND_BYTE && bits_held == 0) begin
            bit_reg   = value;
            bits_held = 8;
        end
        while (run.size() < MAX_EMIT_PER_ITEM && produced < size_limit) begin
            if (tok_phase == PH_COPY) begin
                // Source before the first byte reads as zero and flags it
                if (32'(copy_dist) <= produced) begin
                    src = produced - 32'(copy_dist);
                    v   = hist_mem[src[HIST_AW-1:0]];
                    bad = 1'b0;
                end else begin
                    v   = 8'h00;
                    bad = 1'b1;
                end
                copy_left = copy_left - 32'd1;
                if (copy_left == 0) tok_phase = PH_FLAG;
                run.push_back(store_byte(v, bad));
            end else if (bits_held == 0) begin
                break;
            end else if (shift_token_bit(r)) begin
                run.push_back(r);
            end
        end
        more = work_left();
        foreach (run[k]) begin
            r = run[k];
            r.last    = (k == run.size() - 1);
            r.pending = more;
            expected_bytes.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        out_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result word: data %0d", m_tdata);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                check_field("data_byte",    want.data,    m_tdata);
                check_field("last_of_run",  want.last,    m_tlast);
                check_field("copy_pending", want.pending, m_tuser[0]);
                check_field("stream_done",  want.done,    m_tuser[1]);
                check_field("bad_distance", want.bad,     m_tuser[2]);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Present one word, hold it until accepted, then idle at random
    task automatic send_word(input logic kind, input logic [7:0] value);
        bit live;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        live = (produced < size_limit);
        decode_word(kind, value);
        if (live) words_sent++;
        if (!steady_rate && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
    endtask

    // Hold off until every expected result is out and the block is idle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_output_size(input logic [31:0] value);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        size_limit = value;
    endtask

    function automatic void put_field(input int value, input int width);
        for (int i = width - 1; i >= 0; i--) token_bits.push_back(bit'((value >> i) & 1));
    endfunction

    function automatic void put_literal(input logic [7:0] value);
        put_field(0, 1);
        put_field(value, LIT_BITS);
        gen_count++;
    endfunction

    // Copy token: distance field, then length fields while all ones
    function automatic void put_copy(input int dist_raw, input int extra);
        int stage;
        int w;
        int full;
        stage = 0;
        put_field(1, 1);
        put_field(dist_raw, DIST_BITS);
        gen_count += LEN_BASE + extra;
        forever begin
            w    = length_field_width(stage);
            full = (1 << w) - 1;
            if (extra < full) begin
                put_field(extra, w);
                break;
            end
            put_field(full, w);
            extra -= full;
            if (stage < LAST_STAGE) stage++;
        end
    endfunction

    // Align the stream to a byte with random literals
    function automatic void pad_to_byte();
        while (token_bits.size() % 8 != 0) put_literal(8'($urandom_range(255)));
    endfunction

    function automatic void put_random_token();
        int pick;
        int extra;
        int hi;
        if ($urandom_range(99) < 55) begin
            put_literal(8'($urandom_range(255)));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 60)      extra = $urandom_range(2);
        else if (pick < 85) extra = $urandom_range(9, 3);
        else if (pick < 95) extra = $urandom_range(40, 10);
        else                extra = $urandom_range(320, 41);
        // Mostly reachable distances, some too far
        if (gen_count >= DIST_BIAS && $urandom_range(99) < 85) begin
            hi = (gen_count > MAX_DISTANCE) ? MAX_DISTANCE : gen_count;
            put_copy($urandom_range(hi, DIST_BIAS) - DIST_BIAS, extra);
        end else begin
            put_copy($urandom_range((1 << DIST_BITS) - 1), extra);
        end
    endfunction

    function automatic void build_burst(input int tokens);
        repeat (tokens) put_random_token();
        pad_to_byte();
    endfunction

    // Drain pending work, now and then with a byte that gets dropped
    task automatic settle_work();
        while (work_left()) begin
            if (bits_held != 0 && $urandom_range(99) < junk_pct)
                send_word(KIND_BYTE, 8'($urandom_range(255)));
            else
                send_word(KIND_DRAIN, 8'($urandom_range(255)));
        end
    endtask

    // Feed queued stream bytes until the stream runs out or finishes
    task automatic feed_stream();
        logic [7:0] b;
        while (token_bits.size() >= 8) begin
            settle_work();
            if (produced >= size_limit) break;
            for (int i = 0; i < 8; i++) b = {b[6:0], logic'(token_bits.pop_front())};
            send_word(KIND_BYTE, b);
        end
        settle_work();
    endtask

    // ---------------------------------------------------------------- tests

    // Size zero: every word is ignored
    task automatic test_size_zero();
        set_output_size(32'h0000_0000);
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_DRAIN, 8'h00);
    endtask

    // Far copy, literal extremes, short copy and a copy through every length stage
    task automatic test_token_forms();
        set_output_size(32'hFFFF_FFFF);
        junk_pct = 50;
        put_copy((1 << DIST_BITS) - 1, 0);
        put_literal(8'h00);
        put_literal(8'hFF);
        put_literal(8'h5A);
        put_copy(0, 3);
        put_copy(5, 3 + 7 + 31 + 255 + 4);
        pad_to_byte();
        feed_stream();
        // Drain with nothing left to do
        send_word(KIND_DRAIN, 8'hA5);
        junk_pct = 15;
    endtask

    // Stop in the middle of a copy, then send words that are ignored
    task automatic test_size_cutoff();
        set_output_size(produced + 32'd5);
        put_literal(8'h81);
        put_literal(8'h7E);
        put_copy(0, 7);
        pad_to_byte();
        feed_stream();
        send_word(KIND_BYTE, 8'h3C);
        send_word(KIND_DRAIN, 8'hC3);
    endtask

    // Resume at full size and run random streams with occasional pauses
    task automatic test_random_stream(input int count);
        int stop;
        stop = words_sent + count;
        set_output_size(32'hFFFF_FFFF);
        while (words_sent < stop) begin
            build_burst($urandom_range(12, 1));
            feed_stream();
            if ($urandom_range(5) == 0) quiesce();
        end
    endtask

    // No idling on either side
    task automatic test_full_rate(input int count);
        int stop;
        stop = words_sent + count;
        steady_rate = 1'b1;
        while (words_sent < stop) begin
            build_burst($urandom_range(12, 1));
            feed_stream();
        end
        quiesce();
        steady_rate = 1'b0;
    endtask

    // Random output sizes that end the stream part way through
    task automatic test_random_cutoffs(input int phases);
        int guard;
        repeat (phases) begin
            set_output_size(produced + 32'($urandom_range(200, 1)));
            guard = 0;
            while (produced < size_limit && guard < 40) begin
                build_burst($urandom_range(12, 1));
                feed_stream();
                guard++;
            end
            send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        // Finish what is left at full size
        set_output_size(32'hFFFF_FFFF);
        feed_stream();
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_size_zero();
        test_token_forms();
        test_size_cutoff();
        test_random_stream(260);
        test_full_rate(80);
        test_random_cutoffs(4);

        quiesce();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Abort a hung run
    initial begin
        #(20_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/lzbd_pkg.sv
hdl/lzbd_ram.sv
hdl/lz_backward_bitstream_decoder.sv
verif/tb.sv
